// ===== hw/rtl/gwawb_pkg.sv =====
package gwawb_pkg;

    // Field widths fixed by the interface.
    localparam int GAIN_W            = 16;
    localparam int THRESH_W          = 10;
    localparam int SUM_WIDTH_DEFAULT = 40;

    // Gains are carried in thousandths; 1000 fits in this many bits.
    localparam int MILLI_BITS = 10;

    // Reset value of the change threshold register.
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(10);

    // Saturated gain value.
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } gwawb_state_t;

endpackage

// ===== hw/rtl/gray_world_awb_gain_update.sv =====
// Gray-world white balance gain update.
//
// Input channel (in_valid/in_ready) takes one item per frame: the red, green
// and blue channel sums. Output channel (out_valid/out_ready) returns one
// item per input: the gains green/red and green/blue in thousandths,
// saturated at 65535, a zero-divisor flag and an apply flag. Apply is set
// when either gain moved by more than change_threshold from the last
// applied pair, in which case the new pair becomes the applied pair. The
// threshold is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle, which the block itself does not enforce.
//
// After acceptance the sequencer forms green*1000, then runs two divisions
// of 17 compare-subtract steps each on one shared subtractor, with a load
// state before each and a final state for the threshold compare. in_ready
// is high only while the sequencer is idle.
//
// The result sits in an output register. If the receiver stalls, the next
// item is still accepted and computed, and it waits in its last cycle until
// the output register frees up. Reset clears the applied gains to zero and
// sets the threshold to 10.
module gray_world_awb_gain_update #(
    parameter int SUM_WIDTH = gwawb_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [SUM_WIDTH-1:0]            red_sum,
    input  logic [SUM_WIDTH-1:0]            green_sum,
    input  logic [SUM_WIDTH-1:0]            blue_sum,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            apply,
    output logic [gwawb_pkg::GAIN_W-1:0]    red_gain_milli,
    output logic [gwawb_pkg::GAIN_W-1:0]    blue_gain_milli,
    output logic                            zero_divisor,
    input  logic                            cfg_wr_en,
    input  logic [gwawb_pkg::THRESH_W-1:0]  cfg_wr_data
);
    import gwawb_pkg::*;

    localparam int NUM_W = SUM_WIDTH + MILLI_BITS;
    localparam int DW    = SUM_WIDTH + GAIN_W;
    localparam int QW    = GAIN_W + 1;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    // Control state.
    gwawb_state_t          state_reg, state_next;
    logic                  side_reg, side_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [THRESH_W-1:0]   thresh_reg, thresh_next;
    logic [GAIN_W-1:0]     last_red_reg, last_red_next;
    logic [GAIN_W-1:0]     last_blue_reg, last_blue_next;
    logic                  out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [SUM_WIDTH-1:0]  r_reg, r_next;
    logic [SUM_WIDTH-1:0]  g_reg, g_next;
    logic [SUM_WIDTH-1:0]  b_reg, b_next;
    logic                  zero_reg, zero_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [DW-1:0]         dsh_reg, dsh_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [GAIN_W-1:0]     red_gain_reg, red_gain_next;
    logic                  apply_reg, apply_next;
    logic [GAIN_W-1:0]     red_out_reg, red_out_next;
    logic [GAIN_W-1:0]     blue_out_reg, blue_out_next;
    logic                  zero_out_reg, zero_out_next;

    // Shared compare-subtract unit.
    logic [DW:0]           sub_full;
    logic                  ge;
    logic [QW-1:0]         q_shift;
    logic [GAIN_W-1:0]     step_gain;
    logic [GAIN_W-1:0]     blue_gain;
    logic [GAIN_W-1:0]     diff_red;
    logic [GAIN_W-1:0]     diff_blue;
    logic                  do_apply;
    logic                  out_free;
    logic [GAIN_W-1:0]     thresh_ext;

    assign sub_full  = {1'b0, DW'(rem_reg)} - {1'b0, dsh_reg};
    assign ge        = ~sub_full[DW];
    assign q_shift   = {q_reg[QW-2:0], ge};
    assign step_gain = q_shift[QW-1] ? GAIN_MAX : q_shift[GAIN_W-1:0];
    assign blue_gain = q_reg[QW-1] ? GAIN_MAX : q_reg[GAIN_W-1:0];

    // Threshold compare against the last applied gains.
    assign diff_red   = (last_red_reg > red_gain_reg) ? last_red_reg - red_gain_reg
                                                      : red_gain_reg - last_red_reg;
    assign diff_blue  = (last_blue_reg > blue_gain) ? last_blue_reg - blue_gain
                                                    : blue_gain - last_blue_reg;
    assign thresh_ext = GAIN_W'(thresh_reg);
    assign do_apply   = (diff_red > thresh_ext) || (diff_blue > thresh_ext);

    assign out_free = ~out_valid_reg | out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = side_reg ? ST_DONE : ST_LOAD;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        side_next      = side_reg;
        cnt_next       = cnt_reg;
        thresh_next    = cfg_wr_en ? cfg_wr_data : thresh_reg;
        last_red_next  = last_red_reg;
        last_blue_next = last_blue_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        r_next         = r_reg;
        g_next         = g_reg;
        b_next         = b_reg;
        zero_next      = zero_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        red_gain_next  = red_gain_reg;
        apply_next     = apply_reg;
        red_out_next   = red_out_reg;
        blue_out_next  = blue_out_reg;
        zero_out_next  = zero_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                r_next    = red_sum;
                g_next    = green_sum;
                b_next    = blue_sum;
                zero_next = (red_sum == '0) || (blue_sum == '0);
                side_next = 1'b0;
            end
            ST_MUL:
            begin
                // green * 1000 as 1024 - 16 - 8.
                num_next = (NUM_W'(g_reg) << 10)
                         - (NUM_W'(g_reg) << 4)
                         - (NUM_W'(g_reg) << 3);
            end
            ST_LOAD:
            begin
                rem_next = num_reg;
                dsh_next = {(side_reg ? b_reg : r_reg), {GAIN_W{1'b0}}};
                cnt_next = CNT_LAST;
                q_next   = '0;
            end
            ST_DIV:
            begin
                // One restoring step; the top bit flags saturation.
                if (ge)
                    rem_next = sub_full[NUM_W-1:0];
                dsh_next = dsh_reg >> 1;
                q_next   = q_shift;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0 && !side_reg)
                begin
                    red_gain_next = step_gain;
                    side_next     = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    apply_next     = do_apply;
                    red_out_next   = red_gain_reg;
                    blue_out_next  = blue_gain;
                    zero_out_next  = zero_reg;
                    if (do_apply)
                    begin
                        last_red_next  = red_gain_reg;
                        last_blue_next = blue_gain;
                    end
                end
            end
            default:
            begin
                side_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_reg      <= 1'b0;
            cnt_reg       <= '0;
            thresh_reg    <= THRESH_RESET;
            last_red_reg  <= '0;
            last_blue_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            cnt_reg       <= cnt_next;
            thresh_reg    <= thresh_next;
            last_red_reg  <= last_red_next;
            last_blue_reg <= last_blue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        g_reg        <= g_next;
        b_reg        <= b_next;
        zero_reg     <= zero_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        red_gain_reg <= red_gain_next;
        apply_reg    <= apply_next;
        red_out_reg  <= red_out_next;
        blue_out_reg <= blue_out_next;
        zero_out_reg <= zero_out_next;
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign apply           = apply_reg;
    assign red_gain_milli  = red_out_reg;
    assign blue_gain_milli = blue_out_reg;
    assign zero_divisor    = zero_out_reg;

endmodule

// ===== hw/rtl/gwawb_checker.sv =====
module gwawb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            apply,
    input logic [gwawb_pkg::GAIN_W-1:0]    red_gain_milli,
    input logic [gwawb_pkg::GAIN_W-1:0]    blue_gain_milli,
    input logic                            zero_divisor
);
    import gwawb_pkg::*;

    // An accepted item makes the block busy, so in_ready drops after acceptance.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("input accepted again too soon");

    // A result cannot appear the cycle right after an item enters an empty output.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared without computation time");

    // A zero divisor always saturates at least one gain.
    a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_divisor) |->
            (red_gain_milli == GAIN_MAX || blue_gain_milli == GAIN_MAX))
        else $error("zero divisor without saturated gain");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(apply) && $stable(red_gain_milli)
             && $stable(blue_gain_milli) && $stable(zero_divisor)))
        else $error("stalled result changed");

endmodule

bind gray_world_awb_gain_update gwawb_checker u_gwawb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .apply           (apply),
    .red_gain_milli  (red_gain_milli),
    .blue_gain_milli (blue_gain_milli),
    .zero_divisor    (zero_divisor)
);
